// ===== src/dgav_pkg.sv =====
package dgav_pkg;

    localparam int NODES = 64;
    localparam int NODE_W = $clog2(NODES);
    localparam int ROW_W = NODE_W + 2;
    localparam int CNT_W = 7;
    localparam logic [CNT_W-1:0] MAX_CNT = 7'd64;

    localparam logic [1:0] CMD_FIELDS = 2'd0;
    localparam logic [1:0] CMD_ROW = 2'd1;
    localparam logic [1:0] CMD_GEOM = 2'd2;
    localparam logic [1:0] CMD_COMPUTE = 2'd3;

    localparam int GEOM_N = 9;

    localparam logic signed [63:0] SAT_MAX = 64'sd2147483647;
    localparam logic signed [63:0] SAT_MIN = -64'sd2147483648;

    // controller to datapath
    typedef struct packed {
        logic       clr;        // clear accumulators at node start
        logic [1:0] entry;      // row entry being gathered
        logic [1:0] dir;        // 0 base, 1 r, 2 s, 3 t
        logic       rd_en;      // issue memory read
        logic       fin_en;     // start chain rule for node
        logic [NODE_W-1:0] node;
    } dgav_cmd_t;

    typedef struct packed {
        logic fin_done;
    } dgav_stat_t;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
        if (x > SAT_MAX)
            return 32'sh7fffffff;
        else if (x < SAT_MIN)
            return 32'sh80000000;
        else
            return x[31:0];
    endfunction

    // round half up from Q32.32 to Q16.16
    function automatic logic signed [63:0] rnd16(input logic signed [63:0] x);
        logic signed [63:0] t;
        t = x + 64'sd32768;
        return t >>> 16;
    endfunction

endpackage

// ===== src/dgav_datapath.sv =====
module dgav_datapath (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_take,
    input  logic [1:0]                   cmd,
    input  logic [dgav_pkg::NODE_W-1:0]  node,
    input  logic [3:0]                   slot,
    input  logic [23:0]                  row_idx,
    input  logic signed [31:0]           coef,
    input  logic signed [31:0]           val_u,
    input  logic signed [31:0]           val_v,
    input  logic signed [31:0]           val_w,
    input  logic signed [31:0]           val_p,
    input  dgav_pkg::dgav_cmd_t          ctl,
    output dgav_pkg::dgav_stat_t         stat,
    output logic signed [31:0]           res_x,
    output logic signed [31:0]           res_y,
    output logic signed [31:0]           res_z,
    output logic signed [31:0]           res_div
);
    import dgav_pkg::*;

    logic [31:0] u_mem [NODES];
    logic [31:0] v_mem [NODES];
    logic [31:0] w_mem [NODES];
    logic [31:0] p_mem [NODES];
    logic [23:0] idx_mem [4*NODES];
    logic [31:0] wt_mem [4*NODES];
    logic signed [31:0] geom_reg [GEOM_N];

    logic [23:0] idx_q;
    logic [31:0] wt_q;
    logic [31:0] fu_q, fv_q, fw_q, fp_q;
    logic [NODE_W-1:0] rd_addr;
    logic [ROW_W-1:0] row_addr;
    logic [1:0] dir_q;
    logic rd_valid_reg;
    logic [1:0] rd_dir_reg;

    // base values held per entry
    logic signed [31:0] bu_reg, bv_reg, bw_reg, bp_reg;
    // derivative accumulators [field*3 + dir-1], four terms of up to 48 bits
    logic signed [49:0] acc_reg [12];
    logic signed [31:0] drv [12];

    assign row_addr = {ctl.node, ctl.entry};
    assign dir_q = ctl.dir;

    always_ff @(posedge clk)
    begin
        if (in_take && cmd == CMD_FIELDS)
        begin
            u_mem[node] <= val_u;
            v_mem[node] <= val_v;
            w_mem[node] <= val_w;
            p_mem[node] <= val_p;
        end
        if (in_take && cmd == CMD_ROW && slot < 4'd4)
        begin
            idx_mem[{node, slot[1:0]}] <= row_idx;
            wt_mem[{node, slot[1:0]}] <= coef;
        end
        if (in_take && cmd == CMD_GEOM && slot < 4'(GEOM_N))
            geom_reg[slot] <= coef;
        idx_q <= idx_mem[row_addr];
        wt_q  <= wt_mem[row_addr];
    end

    // field address from the row entry already fetched
    always_comb
    begin
        case (dir_q)
            2'd0: rd_addr = idx_q[5:0];
            2'd1: rd_addr = idx_q[11:6];
            2'd2: rd_addr = idx_q[17:12];
            default: rd_addr = idx_q[23:18];
        endcase
    end

    always_ff @(posedge clk)
    begin
        fu_q <= u_mem[rd_addr];
        fv_q <= v_mem[rd_addr];
        fw_q <= w_mem[rd_addr];
        fp_q <= p_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_valid_reg <= 1'b0;
            rd_dir_reg <= 2'd0;
        end
        else
        begin
            rd_valid_reg <= ctl.rd_en;
            rd_dir_reg <= dir_q;
        end
    end

    // products for the four fields, one direction per cycle
    logic signed [31:0] df [4];
    logic signed [31:0] fv [4];
    logic signed [31:0] bv [4];
    logic signed [63:0] prod [4];
    assign fv[0] = fu_q;
    assign fv[1] = fv_q;
    assign fv[2] = fw_q;
    assign fv[3] = fp_q;
    assign bv[0] = bu_reg;
    assign bv[1] = bv_reg;
    assign bv[2] = bw_reg;
    assign bv[3] = bp_reg;

    always_comb
    begin
        for (int f = 0; f < 4; f++)
        begin
            df[f] = sat32(64'(fv[f]) - 64'(bv[f]));
            prod[f] = rnd16(64'(df[f]) * 64'(signed'(wt_q)));
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.clr)
            for (int k = 0; k < 12; k++)
                acc_reg[k] <= '0;
        else if (rd_valid_reg && rd_dir_reg == 2'd0)
        begin
            bu_reg <= fu_q;
            bv_reg <= fv_q;
            bw_reg <= fw_q;
            bp_reg <= fp_q;
        end
        else if (rd_valid_reg)
            for (int f = 0; f < 4; f++)
                acc_reg[f*3 + int'(rd_dir_reg) - 1] <=
                    acc_reg[f*3 + int'(rd_dir_reg) - 1] + 50'(prod[f]);
    end

    always_comb
    begin
        for (int k = 0; k < 12; k++)
            drv[k] = sat32(64'(acc_reg[k] + 50'sd1) >>> 1);
    end

    // chain rule: three steps, c = 0..2 per geometry column
    logic [1:0] step_reg;
    logic busy_reg;
    logic signed [63:0] px_reg, py_reg, pz_reg, dv_reg;
    logic signed [63:0] cp0, cp1, cp2, cd;
    logic signed [31:0] gr, gs, gt, ar, as_, at;
    logic signed [63:0] t0, t1, t2;

    always_comb
    begin
        gr = geom_reg[step_reg];
        gs = geom_reg[4'(step_reg) + 4'd3];
        gt = geom_reg[4'(step_reg) + 4'd6];
        case (step_reg)
            2'd0: begin ar = drv[0]; as_ = drv[1]; at = drv[2]; end
            2'd1: begin ar = drv[3]; as_ = drv[4]; at = drv[5]; end
            default: begin ar = drv[6]; as_ = drv[7]; at = drv[8]; end
        endcase
        cd = rnd16(64'(gr) * 64'(ar)) + rnd16(64'(gs) * 64'(as_))
           + rnd16(64'(gt) * 64'(at));
        t0 = rnd16(64'(gr) * 64'(drv[9]));
        t1 = rnd16(64'(gs) * 64'(drv[10]));
        t2 = rnd16(64'(gt) * 64'(drv[11]));
        cp0 = t0 + t1 + t2;
        cp1 = cp0;
        cp2 = cp0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= 2'd0;
            busy_reg <= 1'b0;
        end
        else if (ctl.fin_en)
        begin
            step_reg <= 2'd0;
            busy_reg <= 1'b1;
        end
        else if (busy_reg)
        begin
            if (step_reg == 2'd2)
                busy_reg <= 1'b0;
            else
                step_reg <= step_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.fin_en)
            dv_reg <= '0;
        else if (busy_reg)
        begin
            dv_reg <= dv_reg + cd;
            case (step_reg)
                2'd0: px_reg <= cp0;
                2'd1: py_reg <= cp1;
                default: pz_reg <= cp2;
            endcase
        end
    end

    assign stat.fin_done = busy_reg && step_reg == 2'd2;

    assign res_x = sat32(-px_reg);
    assign res_y = sat32(-py_reg);
    assign res_z = sat32(-pz_reg);
    assign res_div = sat32(-dv_reg);

endmodule

// ===== src/dgav_ctrl.sv =====
module dgav_ctrl (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [dgav_pkg::CNT_W-1:0]   count,
    input  dgav_pkg::dgav_stat_t         stat,
    output dgav_pkg::dgav_cmd_t          ctl,
    output logic                         busy,
    output logic                         res_load,
    output logic [dgav_pkg::NODE_W-1:0]  res_node,
    output logic                         res_last,
    input  logic                         res_full
);
    import dgav_pkg::*;

    typedef enum logic [2:0] {IDLE, ROWRD, GATHER, DRAIN, CHAIN, EMIT} state_t;

    state_t state_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [NODE_W-1:0] node_reg;
    logic [1:0] entry_reg;
    logic [1:0] dir_reg;
    logic [1:0] drain_reg;

    always_comb
    begin
        ctl.clr = state_reg == IDLE || state_reg == EMIT;
        ctl.entry = entry_reg;
        ctl.dir = dir_reg;
        ctl.rd_en = state_reg == GATHER;
        ctl.fin_en = state_reg == DRAIN && drain_reg == 2'd1;
        ctl.node = node_reg;
    end

    assign busy = state_reg != IDLE;
    assign res_load = state_reg == EMIT && !res_full;
    assign res_node = node_reg;
    assign res_last = 7'(node_reg) + 7'd1 == cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= IDLE;
            cnt_reg <= '0;
            node_reg <= '0;
            entry_reg <= '0;
            dir_reg <= '0;
            drain_reg <= '0;
        end
        else
        begin
            case (state_reg)
                IDLE:
                begin
                    if (start)
                    begin
                        cnt_reg <= count > MAX_CNT ? MAX_CNT : count;
                        node_reg <= '0;
                        entry_reg <= '0;
                        dir_reg <= '0;
                        if (count != '0)
                            state_reg <= ROWRD;
                    end
                end
                ROWRD:
                    state_reg <= GATHER;
                GATHER:
                begin
                    // base then r, s, t for this entry
                    dir_reg <= dir_reg + 2'd1;
                    if (dir_reg == 2'd3)
                    begin
                        entry_reg <= entry_reg + 2'd1;
                        state_reg <= entry_reg == 2'd3 ? DRAIN : ROWRD;
                        drain_reg <= '0;
                    end
                end
                DRAIN:
                begin
                    drain_reg <= drain_reg + 2'd1;
                    if (drain_reg == 2'd1)
                        state_reg <= CHAIN;
                end
                CHAIN:
                    if (stat.fin_done)
                        state_reg <= EMIT;
                EMIT:
                begin
                    if (!res_full)
                    begin
                        if (res_last)
                            state_reg <= IDLE;
                        else
                        begin
                            node_reg <= node_reg + NODE_W'(1);
                            state_reg <= ROWRD;
                        end
                    end
                end
                default:
                    state_reg <= IDLE;
            endcase
        end
    end

endmodule

// ===== src/dg_acoustics_volume_kernel_core.sv =====
// channel   direction  handshake
// in        input      in_valid / in_stall
// out       output     out_valid / out_stall
// cfg       input      cfg_we, cfg_data
// loads are accepted while idle; a compute works per node through four row
// reads and sixteen single-port field reads, the drain, a three-step chain
// rule unit and the emit. one output register holds a finished result; the
// next node proceeds while it waits. reset returns node_count to 64. input
// is stalled for the whole compute.
module dg_acoustics_volume_kernel_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [6:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  cmd,
    input  logic [5:0]  node,
    input  logic [3:0]  slot,
    input  logic [5:0]  base_index,
    input  logic [5:0]  r_index,
    input  logic [5:0]  s_index,
    input  logic [5:0]  t_index,
    input  logic signed [31:0] coef,
    input  logic signed [31:0] val_u,
    input  logic signed [31:0] val_v,
    input  logic signed [31:0] val_w,
    input  logic signed [31:0] val_p,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [5:0]  out_node,
    output logic signed [31:0] rhs_x,
    output logic signed [31:0] rhs_y,
    output logic signed [31:0] rhs_z,
    output logic signed [31:0] rhs_div,
    output logic        last
);
    import dgav_pkg::*;

    logic [CNT_W-1:0] count_reg;
    logic in_take, busy, res_load, res_last;
    logic [NODE_W-1:0] res_node;
    logic signed [31:0] rx, ry, rz, rd;
    dgav_cmd_t ctl;
    dgav_stat_t stat;
    logic res_full;

    assign in_stall = busy;
    assign in_take = in_valid && !busy;
    assign res_full = out_valid && out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= MAX_CNT;
        else if (cfg_we)
            count_reg <= cfg_data;
    end

    dgav_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .in_take(in_take), .cmd(cmd), .node(node),
        .slot(slot), .row_idx({t_index, s_index, r_index, base_index}),
        .coef(coef), .val_u(val_u), .val_v(val_v), .val_w(val_w), .val_p(val_p),
        .ctl(ctl), .stat(stat), .res_x(rx), .res_y(ry), .res_z(rz), .res_div(rd)
    );

    dgav_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .start(in_take && cmd == CMD_COMPUTE),
        .count(count_reg), .stat(stat), .ctl(ctl),
        .busy(busy), .res_load(res_load), .res_node(res_node),
        .res_last(res_last), .res_full(res_full)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid <= 1'b0;
        else if (res_load)
            out_valid <= 1'b1;
        else if (!out_stall)
            out_valid <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            out_node <= res_node;
            rhs_x <= rx;
            rhs_y <= ry;
            rhs_z <= rz;
            rhs_div <= rd;
            last <= res_last;
        end
    end

endmodule

// ===== bench/tb_top.sv =====
module tb_top;
    import dgav_pkg::*;

    typedef struct {
        logic [1:0]  cmd;
        logic [5:0]  node;
        logic [3:0]  slot;
        logic [5:0]  bi, ri, si, ti;
        logic signed [31:0] coef;
        logic signed [31:0] vu, vv, vw, vp;
    } kern_item_t;

    typedef struct {
        logic [5:0]  node;
        logic signed [31:0] x, y, z, dv;
        logic        last;
    } rhs_t;

    class rhs_scoreboard;
        longint fld[4][64];
        int     ix[256][4];
        longint wt[256];
        longint geo[9];
        int     node_cnt;
        rhs_t   pending[$];
        int     errors;

        function new();
            node_cnt = 64;
            errors = 0;
        endfunction

        function longint sat(longint x);
            if (x > 64'sd2147483647)
                return 64'sd2147483647;
            if (x < -64'sd2147483648)
                return -64'sd2147483648;
            return x;
        endfunction

        function longint rnd(longint x);
            return (x + 32768) >>> 16;
        endfunction

        // half the weighted sum of gathered differences, dir 1..3 = r, s, t
        function longint ref_slope(int f, int n, int dir);
            longint acc;
            longint diff;
            acc = 0;
            for (int j = 0; j < 4; j++)
            begin
                diff = sat(fld[f][ix[4*n+j][dir]] - fld[f][ix[4*n+j][0]]);
                acc += rnd(diff * wt[4*n+j]);
            end
            return sat((acc + 1) >>> 1);
        endfunction

        function longint to_xyz(int c, longint dr, longint ds, longint dt);
            return rnd(geo[c] * dr) + rnd(geo[c+3] * ds) + rnd(geo[c+6] * dt);
        endfunction

        function void note_input(kern_item_t it);
            int cnt;
            longint d[4][3];
            longint dv;
            rhs_t r;
            case (it.cmd)
                CMD_FIELDS:
                begin
                    fld[0][it.node] = longint'(it.vu);
                    fld[1][it.node] = longint'(it.vv);
                    fld[2][it.node] = longint'(it.vw);
                    fld[3][it.node] = longint'(it.vp);
                end
                CMD_ROW:
                begin
                    if (it.slot < 4)
                    begin
                        ix[4*it.node+it.slot][0] = int'(it.bi);
                        ix[4*it.node+it.slot][1] = int'(it.ri);
                        ix[4*it.node+it.slot][2] = int'(it.si);
                        ix[4*it.node+it.slot][3] = int'(it.ti);
                        wt[4*it.node+it.slot] = longint'(it.coef);
                    end
                end
                CMD_GEOM:
                begin
                    if (it.slot < GEOM_N)
                        geo[it.slot] = longint'(it.coef);
                end
                default:
                begin
                    cnt = node_cnt > 64 ? 64 : node_cnt;
                    for (int n = 0; n < cnt; n++)
                    begin
                        for (int f = 0; f < 4; f++)
                            for (int k = 0; k < 3; k++)
                                d[f][k] = ref_slope(f, n, k + 1);
                        dv = to_xyz(0, d[0][0], d[0][1], d[0][2])
                           + to_xyz(1, d[1][0], d[1][1], d[1][2])
                           + to_xyz(2, d[2][0], d[2][1], d[2][2]);
                        r.node = 6'(n);
                        r.x = 32'(sat(-to_xyz(0, d[3][0], d[3][1], d[3][2])));
                        r.y = 32'(sat(-to_xyz(1, d[3][0], d[3][1], d[3][2])));
                        r.z = 32'(sat(-to_xyz(2, d[3][0], d[3][1], d[3][2])));
                        r.dv = 32'(sat(-dv));
                        r.last = (n + 1 == cnt);
                        pending.push_back(r);
                    end
                end
            endcase
        endfunction

        function void check_result(rhs_t got);
            rhs_t e;
            if (pending.size() == 0)
            begin
                $error("unexpected result for node %0d", got.node);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.node !== e.node)
            begin
                $error("out_node expected %0d actual %0d", e.node, got.node);
                errors++;
            end
            if (got.x !== e.x)
            begin
                $error("rhs_x expected %0d actual %0d", e.x, got.x);
                errors++;
            end
            if (got.y !== e.y)
            begin
                $error("rhs_y expected %0d actual %0d", e.y, got.y);
                errors++;
            end
            if (got.z !== e.z)
            begin
                $error("rhs_z expected %0d actual %0d", e.z, got.z);
                errors++;
            end
            if (got.dv !== e.dv)
            begin
                $error("rhs_div expected %0d actual %0d", e.dv, got.dv);
                errors++;
            end
            if (got.last !== e.last)
            begin
                $error("last expected %0d actual %0d", e.last, got.last);
                errors++;
            end
        endfunction
    endclass

    // nodes whose fields are loaded up front; counts stay at or below it, indices below it
    localparam int USED = 8;

    logic clk = 0;
    logic rst_n = 0;
    logic cfg_we = 0;
    logic [6:0] cfg_data = '0;
    logic in_valid = 0;
    logic in_stall;
    logic [1:0] cmd = '0;
    logic [5:0] node = '0;
    logic [3:0] slot = '0;
    logic [5:0] base_index = '0, r_index = '0, s_index = '0, t_index = '0;
    logic signed [31:0] coef = '0, val_u = '0, val_v = '0, val_w = '0, val_p = '0;
    logic out_valid;
    logic out_stall = 0;
    logic [5:0] out_node;
    logic signed [31:0] rhs_x, rhs_y, rhs_z, rhs_div;
    logic last;

    rhs_scoreboard sb = new();
    int idle_pct = 0;
    int stall_pct = 0;
    int quiet_cycles = 0;
    localparam int QUIET_LIMIT = 20000;

    dg_acoustics_volume_kernel_core u_dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall), .cmd(cmd), .node(node),
        .slot(slot), .base_index(base_index), .r_index(r_index),
        .s_index(s_index), .t_index(t_index), .coef(coef), .val_u(val_u),
        .val_v(val_v), .val_w(val_w), .val_p(val_p), .out_valid(out_valid),
        .out_stall(out_stall), .out_node(out_node), .rhs_x(rhs_x),
        .rhs_y(rhs_y), .rhs_z(rhs_z), .rhs_div(rhs_div), .last(last)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
        out_stall <= ($urandom_range(99) < stall_pct);

    // transaction monitors
    always @(posedge clk)
    begin
        kern_item_t it;
        rhs_t r;
        if (rst_n && in_valid && !in_stall)
        begin
            it.cmd = cmd; it.node = node; it.slot = slot;
            it.bi = base_index; it.ri = r_index; it.si = s_index; it.ti = t_index;
            it.coef = coef; it.vu = val_u; it.vv = val_v; it.vw = val_w;
            it.vp = val_p;
            sb.note_input(it);
        end
        if (rst_n && out_valid && !out_stall)
        begin
            r.node = out_node; r.x = rhs_x; r.y = rhs_y; r.z = rhs_z;
            r.dv = rhs_div; r.last = last;
            sb.check_result(r);
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > QUIET_LIMIT)
        begin
            $display("FAIL dg_acoustics_volume_kernel_core");
            $finish;
        end
    end

    function automatic logic [31:0] pick_val();
        case ($urandom_range(7))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return 32'($urandom_range(131072) - 65536);
            default: return $urandom;
        endcase
    endfunction

    task automatic send(kern_item_t it);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 0;
            @(posedge clk);
        end
        cmd <= it.cmd; node <= it.node; slot <= it.slot;
        base_index <= it.bi; r_index <= it.ri; s_index <= it.si; t_index <= it.ti;
        coef <= it.coef; val_u <= it.vu; val_v <= it.vv; val_w <= it.vw;
        val_p <= it.vp;
        in_valid <= 1;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    task automatic send_fields(int n, logic [31:0] u, logic [31:0] v,
                               logic [31:0] w, logic [31:0] p);
        kern_item_t it;
        it = '{default: '0};
        it.cmd = CMD_FIELDS; it.node = 6'(n);
        it.vu = u; it.vv = v; it.vw = w; it.vp = p;
        it.coef = $urandom; it.slot = 4'($urandom);
        send(it);
    endtask

    task automatic send_row(int n, int sl, int b, int r, int s, int t,
                            logic [31:0] c);
        kern_item_t it;
        it = '{default: '0};
        it.cmd = CMD_ROW; it.node = 6'(n); it.slot = 4'(sl);
        it.bi = 6'(b); it.ri = 6'(r); it.si = 6'(s); it.ti = 6'(t); it.coef = c;
        it.vu = $urandom; it.vp = $urandom;
        send(it);
    endtask

    task automatic send_geom(int sl, logic [31:0] c);
        kern_item_t it;
        it = '{default: '0};
        it.cmd = CMD_GEOM; it.slot = 4'(sl); it.coef = c;
        it.node = 6'($urandom); it.bi = 6'($urandom);
        send(it);
    endtask

    task automatic send_compute();
        kern_item_t it;
        it = '{default: '0};
        it.cmd = CMD_COMPUTE;
        it.node = 6'($urandom); it.slot = 4'($urandom); it.coef = $urandom;
        send(it);
    endtask

    task automatic wait_drained();
        @(posedge clk);
        while (sb.pending.size() != 0)
            @(posedge clk);
    endtask

    // only while nothing is in flight
    task automatic set_count(int v);
        in_valid <= 0;
        wait_drained();
        repeat (60) @(posedge clk);
        cfg_we <= 1;
        cfg_data <= 7'(v);
        sb.node_cnt = v;
        @(posedge clk);
        cfg_we <= 0;
    endtask

    task automatic random_items(int num);
        int k;
        for (int i = 0; i < num; i++)
        begin
            k = $urandom_range(99);
            if (k < 25)
                send_fields($urandom_range(63), pick_val(), pick_val(), pick_val(),
                            pick_val());
            else if (k < 55)
                send_row($urandom_range(63), $urandom_range(3),
                         $urandom_range(USED - 1), $urandom_range(USED - 1),
                         $urandom_range(USED - 1), $urandom_range(USED - 1),
                         pick_val());
            else if (k < 65)
                send_geom($urandom_range(8), pick_val());
            else if (k < 72)
            begin
                // bad slot, ignored
                if ($urandom_range(1))
                    send_row($urandom_range(63), $urandom_range(15, 4),
                             $urandom_range(63), $urandom_range(63),
                             $urandom_range(63), $urandom_range(63), $urandom);
                else
                    send_geom($urandom_range(15, 9), $urandom);
            end
            else
                send_compute();
        end
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // fill the stores of the nodes in use so no compute reads an unwritten entry
        for (int n = 0; n < USED; n++)
            send_fields(n, $urandom, $urandom, $urandom, $urandom);
        for (int n = 0; n < USED; n++)
            for (int j = 0; j < 4; j++)
                send_row(n, j, $urandom_range(USED - 1), $urandom_range(USED - 1),
                         $urandom_range(USED - 1), $urandom_range(USED - 1),
                         $urandom);
        for (int g = 0; g < GEOM_N; g++)
            send_geom(g, $urandom_range(131072));

        set_count(USED);
        send_compute();

        // extremes: saturating differences and products, ignored slots, counts of 0 and 1
        set_count(2);
        send_fields(0, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h7fffffff);
        send_fields(1, 32'h80000000, 32'h7fffffff, 32'h80000000, 32'h80000000);
        send_row(0, 0, 1, 0, 0, 0, 32'h7fffffff);
        send_row(0, 1, 1, 0, 1, 0, 32'h80000000);
        send_row(1, 0, 0, 1, 1, 1, 32'h80000000);
        send_row(1, 3, 7, 7, 7, 7, 32'h00000000);
        send_geom(0, 32'h7fffffff);
        send_geom(4, 32'h80000000);
        send_geom(8, 32'hffffffff);
        send_row(2, 4, 0, 0, 0, 0, 32'h12345678);
        send_row(2, 15, 63, 63, 63, 63, 32'hffffffff);
        send_geom(9, 32'h7fffffff);
        send_geom(15, 32'h80000000);
        send_compute();
        set_count(0);
        send_compute();
        set_count(1);
        send_compute();

        idle_pct = 0;  stall_pct = 0;
        random_items(22);
        set_count($urandom_range(USED, 2));
        idle_pct = 72; stall_pct = 0;
        random_items(22);
        set_count($urandom_range(USED, 1));
        idle_pct = 0;  stall_pct = 72;
        random_items(22);
        set_count($urandom_range(USED, 1));
        idle_pct = 25; stall_pct = 25;
        random_items(22);
        in_valid <= 0;

        wait_drained();
        repeat (60) @(posedge clk);
        if (sb.errors == 0)
            $display("PASS dg_acoustics_volume_kernel_core");
        else
            $display("FAIL dg_acoustics_volume_kernel_core");
        $finish;
    end
endmodule

// ===== sim.f =====
src/dgav_pkg.sv
src/dgav_datapath.sv
src/dgav_ctrl.sv
src/dg_acoustics_volume_kernel_core.sv
bench/tb_top.sv
